[src/sli_pkg.sv]
// Package with the beat types, command codes and control structs of the sorted list block.
package sli_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int COUNT_W = 7;

    typedef struct packed {
        logic               command;
        logic signed [31:0] value;
    } sli_in_t;

    typedef struct packed {
        logic               found;
        logic               status;
        logic [COUNT_W-1:0] count;
    } sli_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input value
        logic idx_top;     // index <= count - 1
        logic idx_clr;     // index <= 0
        logic idx_dec;
        logic idx_inc;
        logic wr_en;
        logic wr_above;    // write at index + 1 instead of index
        logic wr_shift;    // write the entry just read instead of the value
        logic cnt_inc;
        logic res_load;    // launch a result beat
        logic res_found;
        logic res_status;
    } sli_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_search;
        logic is_full;
        logic is_empty;
        logic rd_ge;       // entry at index >= held value, signed
        logic rd_eq;       // entry at index == held value
        logic idx_zero;
        logic idx_last;    // index is the last held entry
    } sli_sts_t;

endpackage

[src/sorted_list_insert_search.sv]
// Top level of the bounded sorted list with insert and search.
//
//  channel | ports                 | handshake
//  --------+-----------------------+-------------------------------------------
//  item    | start, busy, item     | beat taken when start is high, busy low
//  result  | done, result          | one-cycle beat marked by done, no stall
//
// The result beat is registered from the last working cycle of an item.
// A full-table insert or a search of an empty table is answered from the idle state.
// An insert moves each entry not below the value up one place, then writes the value.
// A search steps up from the first entry until a match or the last held entry.
// One RAM read each cycle, with one write during an insert, sets the pace of one entry per cycle.
// Reset empties the table at once; busy is low during the result beat.
module sorted_list_insert_search #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sli_pkg::sli_in_t  item,
    output logic              done,
    output sli_pkg::sli_out_t result
);

    sli_pkg::sli_cmd_t cmd;
    sli_pkg::sli_sts_t sts;

    sli_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .sts  (sts),
        .cmd  (cmd)
    );

    sli_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .result(result)
    );

endmodule

[src/sli_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/sli_ctrl.sv]
// Controller state machine that sequences insert and search over the entry RAM.
module sli_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sli_pkg::sli_sts_t sts,
    output sli_pkg::sli_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_INS_CMP  = 2'd1;
    localparam logic [1:0] ST_INS_PUT  = 2'd2;
    localparam logic [1:0] ST_SRCH_CMP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!sts.in_search)
                    begin
                        if (sts.is_full)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = sli_pkg::STATUS_FULL;
                        end
                        else if (sts.is_empty)
                        begin
                            cmd.load    = 1'b1;
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_INS_PUT;
                        end
                        else
                        begin
                            cmd.load    = 1'b1;
                            cmd.idx_top = 1'b1;
                            state_next  = ST_INS_CMP;
                        end
                    end
                    else
                    begin
                        if (sts.is_empty)
                        begin
                            cmd.res_load = 1'b1;
                        end
                        else
                        begin
                            cmd.load    = 1'b1;
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_SRCH_CMP;
                        end
                    end
                end
            end
            ST_INS_CMP:
            begin
                // Walk down from the top, moving each entry not below the value up one place.
                cmd.wr_en    = 1'b1;
                cmd.wr_above = 1'b1;
                if (sts.rd_ge)
                begin
                    cmd.wr_shift = 1'b1;
                    if (sts.idx_zero)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                    end
                end
                else
                begin
                    cmd.cnt_inc  = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_INS_PUT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.cnt_inc  = 1'b1;
                cmd.res_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SRCH_CMP:
            begin
                if (sts.rd_eq)
                begin
                    cmd.res_load  = 1'b1;
                    cmd.res_found = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (sts.idx_last)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/sli_dp.sv]
// Datapath: entry RAM, index and fill counters, compare logic and result registers.
module sli_dp #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sli_pkg::sli_in_t  item,
    input  sli_pkg::sli_cmd_t cmd,
    output sli_pkg::sli_sts_t sts,
    output logic              done,
    output sli_pkg::sli_out_t result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + sli_pkg::COUNT_W;

    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] value_reg;
    logic               done_reg;
    logic               found_reg;
    logic               status_reg;

    logic [31:0]        rd_data;
    logic [31:0]        wr_data;
    logic [AW-1:0]      wr_addr;
    logic [XW-1:0]      count_wide;

    sli_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (cmd.wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(idx_next),
        .rdata(rd_data)
    );

    // The RAM reads at the next index so the data lines up with idx_reg.
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_top)
        begin
            idx_next = AW'(count_reg - 1'b1);
        end
        else if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - 1'b1;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    assign count_next = cmd.cnt_inc ? count_reg + 1'b1 : count_reg;
    assign wr_data    = cmd.wr_shift ? rd_data : value_reg;
    assign wr_addr    = cmd.wr_above ? idx_reg + 1'b1 : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            value_reg <= item.value;
        end
        if (cmd.res_load)
        begin
            found_reg  <= cmd.res_found;
            status_reg <= cmd.res_status;
        end
    end

    assign sts.in_search = (item.command == sli_pkg::CMD_SEARCH);
    assign sts.is_full   = (count_reg == CW'(CAPACITY));
    assign sts.is_empty  = (count_reg == '0);
    assign sts.rd_ge     = ($signed(rd_data) >= value_reg);
    assign sts.rd_eq     = (rd_data == value_reg);
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.idx_last  = ((CW'(idx_reg) + 1'b1) == count_reg);

    assign count_wide    = XW'(count_reg);
    assign done          = done_reg;
    assign result.found  = found_reg;
    assign result.status = status_reg;
    assign result.count  = count_wide[sli_pkg::COUNT_W-1:0];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count did not advance by one on insert");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == sli_pkg::STATUS_FULL) |-> count_reg == CW'(CAPACITY))
        else $error("full status reported while table not full");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> result.status == sli_pkg::STATUS_DONE)
        else $error("found and full status both set");
`endif

endmodule

[tb/sli_tb_pkg.sv]
// Mirror of the sorted table that predicts and checks the result beats.
`timescale 1ns / 1ps

package sli_tb_pkg;

    class sorted_table_mirror;

        int                capacity;
        int                mirror_entries[];
        int                mirror_count;
        sli_pkg::sli_out_t pending_results[$];
        int                mismatches;

        function new(int cap);
            capacity       = cap;
            mirror_entries = new[cap];
            mirror_count   = 0;
            mismatches     = 0;
        endfunction

        function int held_count();
            return mirror_count;
        endfunction

        function int held_value(int idx);
            return mirror_entries[idx];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Works out the result of one accepted item and queues it.
        function void note_item(sli_pkg::sli_in_t beat);
            sli_pkg::sli_out_t want;
            int                v;
            int                pos;
            v           = beat.value;
            want        = '0;
            want.status = sli_pkg::STATUS_DONE;
            if (beat.command == sli_pkg::CMD_INSERT)
            begin
                if (mirror_count >= capacity)
                begin
                    want.status = sli_pkg::STATUS_FULL;
                end
                else
                begin
                    // The new value goes ahead of any equal entries.
                    pos = 0;
                    while (pos < mirror_count && mirror_entries[pos] < v)
                        pos++;
                    for (int i = mirror_count; i > pos; i--)
                        mirror_entries[i] = mirror_entries[i - 1];
                    mirror_entries[pos] = v;
                    mirror_count++;
                end
            end
            else
            begin
                for (int i = 0; i < mirror_count; i++)
                begin
                    if (mirror_entries[i] == v)
                        want.found = 1'b1;
                end
            end
            want.count = mirror_count[sli_pkg::COUNT_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void check_result(sli_pkg::sli_out_t got);
            sli_pkg::sli_out_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: found=%0b status=%0b count=%0d",
                             got.found, got.status, got.count);
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found || got.status !== want.status ||
                got.count !== want.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch (found/status/count): want %0b/%0b/%0d got %0b/%0b/%0d",
                             want.found, want.status, want.count,
                             got.found, got.status, got.count);
            end
        endfunction

        function void close_out();
            if (pending_results.size() != 0)
            begin
                mismatches += pending_results.size();
                $display("%0d result beats never arrived", pending_results.size());
            end
        endfunction

    endclass

endpackage

[tb/tb_sorted_list_insert_search.sv]
// Top of the sorted list testbench: clock, reset, stimulus and result monitor.
`timescale 1ns / 1ps

module tb_sorted_list_insert_search;

    localparam int CAP         = 64;
    localparam int RANDOM_BEATS = 1575;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int INT_MIN     = 32'sh8000_0000;
    localparam int INT_MAX     = 32'sh7FFF_FFFF;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    sli_pkg::sli_in_t  item;
    logic              done;
    sli_pkg::sli_out_t result;

    sli_tb_pkg::sorted_table_mirror tracker;
    bit                             no_idle;

    sorted_list_insert_search #(
        .CAPACITY(CAP)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(result);
    end

    // Ends the run when no beat moves for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                idle = 0;
            else
                idle++;
        end
        $display("sorted_list_insert_search regression: fail");
        $finish;
    end

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return ($urandom_range(0, 1) != 0) ? INT_MIN : INT_MAX;
            1: return $urandom_range(0, 1) - 1;
            2, 3: return int'($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    // Search targets lean toward held values and their neighbors.
    function automatic int pick_target();
        int r;
        int n;
        int v;
        n = tracker.held_count();
        r = $urandom_range(0, 99);
        if (n > 0 && r < 45)
            return tracker.held_value($urandom_range(0, n - 1));
        if (n > 0 && r < 65)
        begin
            v = tracker.held_value($urandom_range(0, n - 1));
            return ($urandom_range(0, 1) != 0) ? v + 1 : v - 1;
        end
        return pick_value();
    endfunction

    task automatic send_beat(input logic cmd, input int val, input int gap);
        sli_pkg::sli_in_t b;
        b.command = cmd;
        b.value   = val;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_item(b);
    endtask

    initial
    begin
        int chance;
        tracker = new(CAP);
        no_idle = 1'b0;
        start <= 1'b0;
        item  <= '0;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Searches of the empty table.
        send_beat(sli_pkg::CMD_SEARCH, 0, 0);
        send_beat(sli_pkg::CMD_SEARCH, INT_MIN, 1);
        // Extremes, signs and a duplicate.
        send_beat(sli_pkg::CMD_INSERT, 0, 0);
        send_beat(sli_pkg::CMD_INSERT, INT_MAX, 0);
        send_beat(sli_pkg::CMD_INSERT, INT_MIN, 2);
        send_beat(sli_pkg::CMD_INSERT, -1, 0);
        send_beat(sli_pkg::CMD_INSERT, 1, 0);
        send_beat(sli_pkg::CMD_INSERT, 0, 0);
        send_beat(sli_pkg::CMD_INSERT, INT_MIN + 1, 3);
        send_beat(sli_pkg::CMD_INSERT, INT_MAX - 1, 0);
        send_beat(sli_pkg::CMD_SEARCH, 0, 0);
        send_beat(sli_pkg::CMD_SEARCH, -1, 0);
        send_beat(sli_pkg::CMD_SEARCH, INT_MIN, 0);
        send_beat(sli_pkg::CMD_SEARCH, INT_MAX, 1);
        send_beat(sli_pkg::CMD_SEARCH, 2, 0);
        send_beat(sli_pkg::CMD_SEARCH, -2, 0);
        send_beat(sli_pkg::CMD_INSERT, 100, 0);
        send_beat(sli_pkg::CMD_INSERT, -100, 0);
        send_beat(sli_pkg::CMD_SEARCH, 100, 0);
        send_beat(sli_pkg::CMD_SEARCH, 99, 0);
        send_beat(sli_pkg::CMD_SEARCH, 32'sh5555_5555, 0);
        send_beat(sli_pkg::CMD_SEARCH, 32'shAAAA_AAAA, 0);

        // The table only grows, so inserts stay sparse until it is full and
        // then keep coming as dropped inserts.
        for (int k = 0; k < RANDOM_BEATS; k++)
        begin
            if (k % 150 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            chance = (tracker.held_count() >= CAP) ? 15 : 8;
            if ($urandom_range(0, 99) < chance)
                send_beat(sli_pkg::CMD_INSERT, pick_value(), pick_gap());
            else
                send_beat(sli_pkg::CMD_SEARCH, pick_target(), pick_gap());
        end
        start <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.close_out();
        if (tracker.mismatches == 0)
            $display("sorted_list_insert_search regression: pass");
        else
            $display("sorted_list_insert_search regression: fail");
        $finish;
    end

endmodule
